>>> design/sbus_frame_parser_assert.svh
// Assertion macros used by the checker file of the frame parser.
`ifndef SBUS_FRAME_PARSER_ASSERT_SVH
`define SBUS_FRAME_PARSER_ASSERT_SVH

// The property is checked only while the reset is released.
`define SBFP_ASSERT_ON(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// The property is checked at every edge, during reset too.
`define SBFP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> design/sbfp_pkg.sv
package sbfp_pkg;

    localparam int FRAME_LEN        = 25;
    localparam int ADDR_W           = $clog2(FRAME_LEN);
    localparam int CHAN_BITS        = 11;
    localparam int NUM_CHANS        = 16;
    localparam int GROUP_CHANS      = 4;
    localparam int GROUP_W          = GROUP_CHANS * CHAN_BITS;
    localparam int CHAN_VEC_W       = NUM_CHANS * CHAN_BITS;
    localparam int CHAN_BYTES       = CHAN_VEC_W / 8;
    localparam int COUNT_W          = 32;
    localparam int DEF_COUNTER_BITS = 32;

    localparam logic [ADDR_W-1:0] FIRST_CHAN_ADDR = ADDR_W'(1);
    localparam logic [ADDR_W-1:0] LAST_CHAN_ADDR  = ADDR_W'(CHAN_BYTES);
    localparam logic [ADDR_W-1:0] FLAG_ADDR       = ADDR_W'(FRAME_LEN - 2);
    localparam logic [ADDR_W-1:0] LAST_ADDR       = ADDR_W'(FRAME_LEN - 1);

    localparam logic [7:0] START_BYTE = 8'h0F;
    localparam logic [7:0] END_BYTE   = 8'h00;

    localparam int FLAG_D17_BIT      = 0;
    localparam int FLAG_D18_BIT      = 1;
    localparam int FLAG_LOST_BIT     = 2;
    localparam int FLAG_FAILSAFE_BIT = 3;

    localparam logic EV_FRAME  = 1'b0;
    localparam logic EV_REJECT = 1'b1;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [7:0]        wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } t_mem_req;

    typedef struct packed {
        logic                  kind;
        logic [CHAN_VEC_W-1:0] chans;
        logic [7:0]            flags;
        logic [COUNT_W-1:0]    good;
        logic [COUNT_W-1:0]    bad;
    } t_event;

endpackage

>>> design/sbfp_store.sv
module sbfp_store
    import sbfp_pkg::*;
(
    input  logic     i_clk,
    input  t_mem_req i_req,
    output logic [7:0] o_rdata
);

    logic [7:0] r_mem [FRAME_LEN];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/sbfp_ctrl.sv
module sbfp_ctrl
    import sbfp_pkg::*;
#(
    parameter int COUNTER_BITS = DEF_COUNTER_BITS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_data_byte,
    input  logic       i_out_free,
    output logic       o_ev_valid,
    output t_event     o_ev,
    output t_mem_req   o_req,
    input  logic [7:0] i_rdata
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECODE,
        ST_RESYNC,
        ST_FINISH
    } t_state;

    t_state                  r_state, n_state;
    logic [ADDR_W-1:0]       r_fill, n_fill;
    logic [ADDR_W-1:0]       r_ptr, n_ptr;
    logic                    r_dv, n_dv;
    logic [ADDR_W-1:0]       r_daddr, n_daddr;
    logic [ADDR_W-1:0]       r_dst, n_dst;
    logic                    r_found, n_found;
    logic                    r_kind, n_kind;
    logic [COUNTER_BITS-1:0] r_good, n_good;
    logic [COUNTER_BITS-1:0] r_bad, n_bad;
    logic [CHAN_VEC_W-1:0]   r_bits;
    logic [7:0]              r_flags;

    logic              accept;
    logic              store_byte;
    logic [ADDR_W-1:0] rd_end;
    logic              issue;
    logic              keep_byte;

    assign o_ready    = (r_state == ST_IDLE);
    assign accept     = i_valid && o_ready;
    assign store_byte = (r_fill != '0) || (i_data_byte == START_BYTE);
    assign rd_end     = (r_state == ST_DECODE) ? FLAG_ADDR : LAST_ADDR;
    assign issue      = ((r_state == ST_DECODE) || (r_state == ST_RESYNC)) && (r_ptr <= rd_end);
    assign keep_byte  = (r_state == ST_RESYNC) && r_dv && (r_found || (i_rdata == START_BYTE));

    always_comb begin
        o_req.re    = issue;
        o_req.raddr = r_ptr;
        o_req.we    = 1'b0;
        o_req.waddr = r_fill;
        o_req.wdata = i_data_byte;
        if (accept && store_byte) begin
            o_req.we = 1'b1;
        end else if (keep_byte) begin
            o_req.we    = 1'b1;
            o_req.waddr = r_dst;
            o_req.wdata = i_rdata;
        end
    end

    always_comb begin
        n_state = r_state;
        n_fill  = r_fill;
        n_ptr   = r_ptr;
        n_dv    = 1'b0;
        n_daddr = r_daddr;
        n_dst   = r_dst;
        n_found = r_found;
        n_kind  = r_kind;
        n_good  = r_good;
        n_bad   = r_bad;
        case (r_state)
            ST_IDLE: begin
                if (accept && store_byte) begin
                    if (r_fill == LAST_ADDR) begin
                        n_ptr   = FIRST_CHAN_ADDR;
                        n_dst   = '0;
                        n_found = 1'b0;
                        if (i_data_byte == END_BYTE) begin
                            n_state = ST_DECODE;
                            n_kind  = EV_FRAME;
                        end else begin
                            n_state = ST_RESYNC;
                            n_kind  = EV_REJECT;
                        end
                    end else begin
                        n_fill = r_fill + ADDR_W'(1);
                    end
                end
            end
            ST_DECODE: begin
                n_dv    = issue;
                n_daddr = r_ptr;
                if (issue) begin
                    n_ptr = r_ptr + ADDR_W'(1);
                end
                if (r_dv && (r_daddr == FLAG_ADDR)) begin
                    n_state = ST_FINISH;
                    n_fill  = '0;
                end
            end
            ST_RESYNC: begin
                n_dv    = issue;
                n_daddr = r_ptr;
                if (issue) begin
                    n_ptr = r_ptr + ADDR_W'(1);
                end
                if (keep_byte) begin
                    n_dst   = r_dst + ADDR_W'(1);
                    n_found = 1'b1;
                end
                if (r_dv && (r_daddr == LAST_ADDR)) begin
                    n_state = ST_FINISH;
                    n_fill  = keep_byte ? (r_dst + ADDR_W'(1)) : r_dst;
                end
            end
            ST_FINISH: begin
                if (i_out_free) begin
                    n_state = ST_IDLE;
                    if (r_kind == EV_FRAME) begin
                        n_good = r_good + COUNTER_BITS'(1);
                    end else begin
                        n_bad = r_bad + COUNTER_BITS'(1);
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_fill  <= '0;
            r_ptr   <= '0;
            r_dv    <= 1'b0;
            r_daddr <= '0;
            r_dst   <= '0;
            r_found <= 1'b0;
            r_kind  <= EV_FRAME;
            r_good  <= '0;
            r_bad   <= '0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_ptr   <= n_ptr;
            r_dv    <= n_dv;
            r_daddr <= n_daddr;
            r_dst   <= n_dst;
            r_found <= n_found;
            r_kind  <= n_kind;
            r_good  <= n_good;
            r_bad   <= n_bad;
        end
    end

    // Channel bytes arrive in address order and shift in from the top.
    always_ff @(posedge i_clk) begin
        if ((r_state == ST_DECODE) && r_dv) begin
            if (r_daddr <= LAST_CHAN_ADDR) begin
                r_bits <= {i_rdata, r_bits[CHAN_VEC_W-1:8]};
            end
            if (r_daddr == FLAG_ADDR) begin
                r_flags <= i_rdata;
            end
        end
    end

    assign o_ev_valid = (r_state == ST_FINISH) && i_out_free;

    always_comb begin
        o_ev.kind  = r_kind;
        o_ev.chans = (r_kind == EV_REJECT) ? '0 : r_bits;
        o_ev.flags = (r_kind == EV_REJECT) ? '0 : r_flags;
        o_ev.good  = COUNT_W'(n_good);
        o_ev.bad   = COUNT_W'(n_bad);
    end

endmodule

>>> design/sbus_frame_parser.sv
// Channel  Direction  Handshake           Payload
// request  in         i_valid / o_ready   i_data_byte
// event    out        o_valid / i_ready   o_event_kind, channel groups, flags, counts
//
// A byte that does not complete a frame is taken without a stall.
// After the byte that completes a frame the input stalls for the reads of the store on a
// decode (bytes 1 to 23) or on a resync (bytes 1 to 24), one read per cycle.
// The event shows on o_valid in the same cycle in which o_ready returns high.
// Reset is synchronous and active low; it empties the frame store and clears both counts.
// A waiting event stalls only the next frame completion; other bytes are still taken.
module sbus_frame_parser
    import sbfp_pkg::*;
#(
    parameter int COUNTER_BITS = DEF_COUNTER_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [7:0]         i_data_byte,
    output logic               o_valid,
    input  logic               i_ready,
    output logic               o_event_kind,
    output logic [GROUP_W-1:0] o_chans_0_to_3,
    output logic [GROUP_W-1:0] o_chans_4_to_7,
    output logic [GROUP_W-1:0] o_chans_8_to_11,
    output logic [GROUP_W-1:0] o_chans_12_to_15,
    output logic [7:0]         o_flag_byte,
    output logic               o_digital_seventeen,
    output logic               o_digital_eighteen,
    output logic               o_lost_flag,
    output logic               o_failsafe_flag,
    output logic [COUNT_W-1:0] o_good_frames,
    output logic [COUNT_W-1:0] o_bad_frames
);

    t_mem_req   mem_req;
    logic [7:0] mem_rdata;
    logic       ev_valid;
    t_event     ev;
    logic       out_free;
    logic       r_out_valid;
    t_event     r_out;

    assign out_free = !r_out_valid || i_ready;

    sbfp_store u_store (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

    sbfp_ctrl #(
        .COUNTER_BITS (COUNTER_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_data_byte (i_data_byte),
        .i_out_free  (out_free),
        .o_ev_valid  (ev_valid),
        .o_ev        (ev),
        .o_req       (mem_req),
        .i_rdata     (mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ev_valid) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ev_valid) begin
            r_out <= ev;
        end
    end

    assign o_valid             = r_out_valid;
    assign o_event_kind        = r_out.kind;
    assign o_chans_0_to_3      = r_out.chans[0*GROUP_W +: GROUP_W];
    assign o_chans_4_to_7      = r_out.chans[1*GROUP_W +: GROUP_W];
    assign o_chans_8_to_11     = r_out.chans[2*GROUP_W +: GROUP_W];
    assign o_chans_12_to_15    = r_out.chans[3*GROUP_W +: GROUP_W];
    assign o_flag_byte         = r_out.flags;
    assign o_digital_seventeen = r_out.flags[FLAG_D17_BIT];
    assign o_digital_eighteen  = r_out.flags[FLAG_D18_BIT];
    assign o_lost_flag         = r_out.flags[FLAG_LOST_BIT];
    assign o_failsafe_flag     = r_out.flags[FLAG_FAILSAFE_BIT];
    assign o_good_frames       = r_out.good;
    assign o_bad_frames        = r_out.bad;

endmodule

>>> design/sbfp_checker.sv
`include "sbus_frame_parser_assert.svh"

module sbfp_checker
    import sbfp_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_ready,
    input logic [7:0]         i_data_byte,
    input logic               o_valid,
    input logic               i_ready,
    input logic               o_event_kind,
    input logic [GROUP_W-1:0] o_chans_0_to_3,
    input logic [GROUP_W-1:0] o_chans_4_to_7,
    input logic [GROUP_W-1:0] o_chans_8_to_11,
    input logic [GROUP_W-1:0] o_chans_12_to_15,
    input logic [7:0]         o_flag_byte,
    input logic               o_digital_seventeen,
    input logic               o_digital_eighteen,
    input logic               o_lost_flag,
    input logic               o_failsafe_flag,
    input logic [COUNT_W-1:0] o_good_frames,
    input logic [COUNT_W-1:0] o_bad_frames
);

    `SBFP_ASSERT_ALWAYS(a_reset_clears_event, i_clk, !i_rst_n |=> !o_valid, "event after reset")

    `SBFP_ASSERT_ON(a_event_holds, i_clk, i_rst_n, o_valid && !i_ready |=> o_valid, "event dropped")

    `SBFP_ASSERT_ON(a_reject_is_empty, i_clk, i_rst_n,
        o_valid && (o_event_kind == EV_REJECT) |-> (o_chans_0_to_3 == '0) &&
        (o_chans_4_to_7 == '0) && (o_chans_8_to_11 == '0) &&
        (o_chans_12_to_15 == '0) && (o_flag_byte == '0), "reject carries data")

    `SBFP_ASSERT_ON(a_event_after_busy, i_clk, i_rst_n, $rose(o_valid) |-> !$past(o_ready),
        "event without frame work")

endmodule

bind sbus_frame_parser sbfp_checker u_sbfp_checker (.*);

>>> tb/sbus_frame_parser_checker.sv
`timescale 1ns / 100ps

module sbus_frame_parser_checker
    import sbfp_pkg::*;
#(
    parameter int COUNTER_BITS = DEF_COUNTER_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_req_valid,
    input  logic               i_req_ready,
    input  logic [7:0]         i_data_byte,
    input  logic               i_ev_valid,
    input  logic               i_ev_ready,
    input  logic               i_event_kind,
    input  logic [GROUP_W-1:0] i_chans_0_to_3,
    input  logic [GROUP_W-1:0] i_chans_4_to_7,
    input  logic [GROUP_W-1:0] i_chans_8_to_11,
    input  logic [GROUP_W-1:0] i_chans_12_to_15,
    input  logic [7:0]         i_flag_byte,
    input  logic               i_digital_seventeen,
    input  logic               i_digital_eighteen,
    input  logic               i_lost_flag,
    input  logic               i_failsafe_flag,
    input  logic [COUNT_W-1:0] i_good_frames,
    input  logic [COUNT_W-1:0] i_bad_frames,
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_requests,
    output int                 o_frames,
    output int                 o_rejects
);

    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic               kind;
        logic [GROUP_W-1:0] grp0;
        logic [GROUP_W-1:0] grp1;
        logic [GROUP_W-1:0] grp2;
        logic [GROUP_W-1:0] grp3;
        logic [7:0]         flags;
        logic               d17;
        logic               d18;
        logic               lost;
        logic               fsafe;
        logic [COUNT_W-1:0] good;
        logic [COUNT_W-1:0] bad;
    } t_frame_result;

    t_frame_result           expected_events [$];
    t_frame_result           head;
    logic [7:0]              frame_store [FRAME_LEN];
    int                      fill_level;
    logic [COUNTER_BITS-1:0] good_count;
    logic [COUNTER_BITS-1:0] bad_count;
    int                      fails;
    int                      requests;
    int                      frames;
    int                      rejects;

    initial begin
        fill_level = 0;
        good_count = '0;
        bad_count  = '0;
        fails      = 0;
        requests   = 0;
        frames     = 0;
        rejects    = 0;
    end

    task automatic parse_byte(input logic [7:0] b);
        t_frame_result         res;
        logic [CHAN_VEC_W-1:0] chan_vec;
        int                    skip;
        if (fill_level == 0 && b != START_BYTE) begin
            return;
        end
        frame_store[fill_level] = b;
        fill_level++;
        if (fill_level != FRAME_LEN) begin
            return;
        end
        res = '0;
        if (frame_store[FRAME_LEN-1] != END_BYTE) begin
            bad_count++;
            res.kind = EV_REJECT;
            // Keep the tail that starts at the next start byte, if any.
            skip = 1;
            while (skip < fill_level && frame_store[skip] != START_BYTE) begin
                skip++;
            end
            fill_level -= skip;
            for (int i = 0; i < fill_level; i++) begin
                frame_store[i] = frame_store[skip+i];
            end
        end else begin
            good_count++;
            for (int i = 0; i < CHAN_BYTES; i++) begin
                chan_vec[8*i +: 8] = frame_store[1+i];
            end
            res.kind  = EV_FRAME;
            res.grp0  = chan_vec[0*GROUP_W +: GROUP_W];
            res.grp1  = chan_vec[1*GROUP_W +: GROUP_W];
            res.grp2  = chan_vec[2*GROUP_W +: GROUP_W];
            res.grp3  = chan_vec[3*GROUP_W +: GROUP_W];
            res.flags = frame_store[FLAG_ADDR];
            res.d17   = res.flags[FLAG_D17_BIT];
            res.d18   = res.flags[FLAG_D18_BIT];
            res.lost  = res.flags[FLAG_LOST_BIT];
            res.fsafe = res.flags[FLAG_FAILSAFE_BIT];
            fill_level = 0;
        end
        res.good = COUNT_W'(good_count);
        res.bad  = COUNT_W'(bad_count);
        expected_events.push_back(res);
    endtask

    task automatic check_field(input string name, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
        if (exp_v !== act_v) begin
            fails++;
            if (fails <= MAX_REPORTS) begin
                $display("Mismatch on %s: expected %h, actual %h", name, exp_v, act_v);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            expected_events.delete();
            fill_level = 0;
            good_count = '0;
            bad_count  = '0;
        end else begin
            if (i_ev_valid && i_ev_ready) begin
                if (expected_events.size() == 0) begin
                    fails++;
                    if (fails <= MAX_REPORTS) begin
                        $display("Event kind %0d arrived with no prediction", i_event_kind);
                    end
                end else begin
                    head = expected_events.pop_front();
                    check_field("event_kind", 64'(head.kind), 64'(i_event_kind));
                    check_field("chans_0_to_3", 64'(head.grp0), 64'(i_chans_0_to_3));
                    check_field("chans_4_to_7", 64'(head.grp1), 64'(i_chans_4_to_7));
                    check_field("chans_8_to_11", 64'(head.grp2), 64'(i_chans_8_to_11));
                    check_field("chans_12_to_15", 64'(head.grp3), 64'(i_chans_12_to_15));
                    check_field("flag_byte", 64'(head.flags), 64'(i_flag_byte));
                    check_field("digital_seventeen", 64'(head.d17), 64'(i_digital_seventeen));
                    check_field("digital_eighteen", 64'(head.d18), 64'(i_digital_eighteen));
                    check_field("lost_flag", 64'(head.lost), 64'(i_lost_flag));
                    check_field("failsafe_flag", 64'(head.fsafe), 64'(i_failsafe_flag));
                    check_field("good_frames", 64'(head.good), 64'(i_good_frames));
                    check_field("bad_frames", 64'(head.bad), 64'(i_bad_frames));
                    if (head.kind == EV_FRAME) begin
                        frames++;
                    end else begin
                        rejects++;
                    end
                end
            end
            if (i_req_valid && i_req_ready) begin
                requests++;
                parse_byte(i_data_byte);
            end
        end
        o_pending    <= expected_events.size();
        o_fail_count <= fails;
        o_requests   <= requests;
        o_frames     <= frames;
        o_rejects    <= rejects;
    end

endmodule

>>> tb/sbus_frame_parser_tb.sv
`timescale 1ns / 100ps

module sbus_frame_parser_tb
    import sbfp_pkg::*;
();

    localparam int IDLE_LIMIT      = 4000;
    localparam int RANDOM_REQUESTS = 580;
    localparam int HOLD_CYCLES     = 400;
    localparam int TAIL_CYCLES     = 60;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_valid     = 1'b0;
    logic               i_ready     = 1'b0;
    logic [7:0]         i_data_byte = 8'h00;
    logic               o_ready;
    logic               o_valid;
    logic               o_event_kind;
    logic [GROUP_W-1:0] o_chans_0_to_3;
    logic [GROUP_W-1:0] o_chans_4_to_7;
    logic [GROUP_W-1:0] o_chans_8_to_11;
    logic [GROUP_W-1:0] o_chans_12_to_15;
    logic [7:0]         o_flag_byte;
    logic               o_digital_seventeen;
    logic               o_digital_eighteen;
    logic               o_lost_flag;
    logic               o_failsafe_flag;
    logic [COUNT_W-1:0] o_good_frames;
    logic [COUNT_W-1:0] o_bad_frames;

    int         fail_count;
    int         pending;
    int         requests;
    int         frames;
    int         rejects;
    logic       hold_go = 1'b0;
    logic [7:0] frame_buf [FRAME_LEN];
    int         burst_left = 0;

    sbus_frame_parser dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_ready             (o_ready),
        .i_data_byte         (i_data_byte),
        .o_valid             (o_valid),
        .i_ready             (i_ready),
        .o_event_kind        (o_event_kind),
        .o_chans_0_to_3      (o_chans_0_to_3),
        .o_chans_4_to_7      (o_chans_4_to_7),
        .o_chans_8_to_11     (o_chans_8_to_11),
        .o_chans_12_to_15    (o_chans_12_to_15),
        .o_flag_byte         (o_flag_byte),
        .o_digital_seventeen (o_digital_seventeen),
        .o_digital_eighteen  (o_digital_eighteen),
        .o_lost_flag         (o_lost_flag),
        .o_failsafe_flag     (o_failsafe_flag),
        .o_good_frames       (o_good_frames),
        .o_bad_frames        (o_bad_frames)
    );

    sbus_frame_parser_checker u_frame_check (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_req_valid         (i_valid),
        .i_req_ready         (o_ready),
        .i_data_byte         (i_data_byte),
        .i_ev_valid          (o_valid),
        .i_ev_ready          (i_ready),
        .i_event_kind        (o_event_kind),
        .i_chans_0_to_3      (o_chans_0_to_3),
        .i_chans_4_to_7      (o_chans_4_to_7),
        .i_chans_8_to_11     (o_chans_8_to_11),
        .i_chans_12_to_15    (o_chans_12_to_15),
        .i_flag_byte         (o_flag_byte),
        .i_digital_seventeen (o_digital_seventeen),
        .i_digital_eighteen  (o_digital_eighteen),
        .i_lost_flag         (o_lost_flag),
        .i_failsafe_flag     (o_failsafe_flag),
        .i_good_frames       (o_good_frames),
        .i_bad_frames        (o_bad_frames),
        .o_fail_count        (fail_count),
        .o_pending           (pending),
        .o_requests          (requests),
        .o_frames            (frames),
        .o_rejects           (rejects)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    initial begin : receiver
        int   mode;
        int   span;
        logic hold_done;
        hold_done = 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_go && !hold_done) begin
                hold_done = 1'b1;
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                mode = $urandom_range(0, 3);
                span = $urandom_range(10, 120);
                repeat (span) begin
                    case (mode)
                        0: i_ready <= 1'b1;
                        1: i_ready <= 1'($urandom_range(0, 1));
                        2: i_ready <= ($urandom_range(0, 3) == 0);
                        default: i_ready <= 1'b0;
                    endcase
                    @(posedge i_clk);
                end
            end
        end
    end

    task automatic send_request(input logic [7:0] b);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            if ($urandom_range(0, 3) != 0) begin
                i_valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
        end
        burst_left--;
        i_valid     <= 1'b1;
        i_data_byte <= b;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    task automatic send_frame(input int len);
        for (int i = 0; i < len; i++) begin
            send_request(frame_buf[i]);
        end
    endtask

    task automatic fill_frame(input logic [7:0] body, input logic [7:0] last);
        frame_buf[0] = START_BYTE;
        for (int i = 1; i < FRAME_LEN - 1; i++) begin
            frame_buf[i] = body;
        end
        frame_buf[FRAME_LEN-1] = last;
    endtask

    task automatic fill_random_frame(input logic [7:0] last);
        frame_buf[0] = START_BYTE;
        for (int i = 1; i < FRAME_LEN - 1; i++) begin
            frame_buf[i] = ($urandom_range(0, 31) == 0) ? START_BYTE : 8'($urandom_range(0, 255));
        end
        frame_buf[FRAME_LEN-1] = last;
    endtask

    task automatic drain();
        i_valid    <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    initial begin : stimulus
        int   counted;
        int   choice;
        logic mid_drained;
        counted     = 0;
        mid_drained = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_request(8'h00);
        send_request(8'hFF);
        send_request(8'h0E);
        send_request(8'hF0);
        fill_frame(8'hFF, END_BYTE);
        send_frame(FRAME_LEN);
        fill_frame(8'h00, END_BYTE);
        send_frame(FRAME_LEN);
        // A start byte inside a rejected frame becomes the head of the next one.
        fill_frame(8'h55, 8'h01);
        frame_buf[12] = START_BYTE;
        send_frame(FRAME_LEN);
        repeat (11) send_request(8'($urandom_range(0, 255)));
        send_request(END_BYTE);
        fill_frame(8'hAA, 8'hFF);
        send_frame(FRAME_LEN);
        send_request(8'h00);
        fill_frame(8'h33, START_BYTE);
        send_frame(FRAME_LEN);
        repeat (23) send_request(8'hC3);
        send_request(END_BYTE);
        drain();

        while (counted < RANDOM_REQUESTS) begin
            if (counted >= 200 && !hold_go) begin
                hold_go <= 1'b1;
            end
            choice = $urandom_range(0, 99);
            if (choice < 75) begin
                fill_random_frame(END_BYTE);
                send_frame(FRAME_LEN);
                counted += FRAME_LEN;
            end else if (choice < 87) begin
                fill_random_frame(8'($urandom_range(1, 255)));
                send_frame(FRAME_LEN);
                counted += FRAME_LEN;
            end else if (choice < 94) begin
                fill_random_frame(END_BYTE);
                choice = $urandom_range(1, FRAME_LEN - 1);
                send_frame(choice);
                counted += choice;
            end else begin
                choice = $urandom_range(1, 6);
                repeat (choice) send_request(8'($urandom_range(0, 255)));
                counted += choice;
            end
            if (counted >= 450 && !mid_drained) begin
                mid_drained = 1'b1;
                drain();
            end
        end
        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Sent %0d requests; checked %0d decoded and %0d rejected frames.",
                 requests, frames, rejects);
        $display("Included resync on embedded start bytes, truncated frames and a long hold-off.");
        if (fail_count == 0 && pending == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("No handshake for %0d cycles, %0d events still pending.", IDLE_LIMIT, pending);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

>>> sim.f
+incdir+design
design/sbfp_pkg.sv
design/sbfp_store.sv
design/sbfp_ctrl.sv
design/sbus_frame_parser.sv
design/sbfp_checker.sv
tb/sbus_frame_parser_checker.sv
tb/sbus_frame_parser_tb.sv
